// ===== src/bfie_pkg.sv =====
// ----------------------------------------------------------------------------
// bfie_pkg
// Shared types, constants and helpers of the bit-field insert/extract engine.
// ----------------------------------------------------------------------------
package bfie_pkg;

  // Byte store geometry: eight byte-wide banks, one row holds eight bytes.
  localparam int STORE_BYTES = 256;
  localparam int NUM_BANKS   = 8;
  localparam int ROWS        = (STORE_BYTES + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic {
    OP_EXTRACT = 1'b0,
    OP_INSERT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SPAN  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic        little_endian;
    logic [10:0] bit_position;
    logic [6:0]  field_length;
    logic [63:0] field_value;
  } bfie_req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [11:0] next_position;
    status_e     status;
  } bfie_rsp_t;

  // Mask of the low len bits; saturates at 64 bits.
  function automatic logic [63:0] len_mask(input logic [6:0] len);
    logic [63:0] m;
    if (len == 7'd0) begin
      m = '0;
    end else if (len >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << len[5:0]) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== src/bit_field_insert_extract_top.sv =====
// ----------------------------------------------------------------------------
// bit_field_insert_extract_top
// Bit-field insert/extract engine over a banked byte store.
// ----------------------------------------------------------------------------
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------
//  request  | start, busy, req_i    | transfer when start high, busy low
//  result   | done_o, rsp_o         | one-cycle strobe, no back-pressure
//
//  An item passes the steps accept (bank read issued), read (bytes
//  assembled into a word), modify (shift, mask, write back, result
//  registered). The result strobe follows in the cycle after modify, in
//  which the next item may already transfer. The single port of each bank
//  sets this order: read and write-back of the same row need separate cycles.
//  After reset a clearing pass over all ROWS rows zeroes the banks; busy
//  stays high meanwhile. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bit_field_insert_extract_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bfie_pkg::bfie_req_t  req_i,
  output logic                 done_o,
  output bfie_pkg::bfie_rsp_t  rsp_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_MOD   = 4'b1000
  } state_e;

  localparam int NB  = bfie_pkg::NUM_BANKS;
  localparam int RAW = bfie_pkg::ROW_AW;

  state_e state_q, state_d;
  logic [RAW-1:0] clr_cnt_q, clr_cnt_d;

  // Request held for the item in flight, plus its decode.
  bfie_pkg::bfie_req_t req_q;
  logic [7:0]  base_q;
  logic [2:0]  bit_q;
  logic [7:0]  span_q;
  logic [3:0]  grp_q;
  logic [11:0] next_q;
  bfie_pkg::status_e status_q;

  logic [63:0] word_q;

  bfie_pkg::bfie_rsp_t rsp_q;
  logic done_q;

  // Decode of the incoming request.
  logic [7:0]  in_base;
  logic [2:0]  in_bit;
  logic [7:0]  in_span;
  logic [3:0]  in_grp;
  logic [11:0] in_next;
  logic [31:0] in_end;
  bfie_pkg::status_e in_status;
  logic        accept;

  // Bank side.
  logic [RAW-1:0] bank_addr  [NB];
  logic           bank_we    [NB];
  logic [7:0]     bank_wdata [NB];
  logic [7:0]     bank_rdata [NB];

  // Modify stage.
  logic [6:0]  shamt;
  logic [63:0] fmask;
  logic [63:0] extracted;
  logic [63:0] merged;
  logic        write_ok;

  // Row of the byte that bank b holds for a group starting at byte base.
  function automatic logic [RAW-1:0] bank_row(input logic [7:0] base, input int b);
    logic [2:0] lane;
    logic [8:0] addr;
    lane = 3'(b) - base[2:0];
    addr = {1'b0, base} + {6'd0, lane};
    return RAW'(addr[8:3]);
  endfunction

  assign accept = start && !busy;

  always_comb begin
    in_base = req_i.bit_position[10:3];
    in_bit  = req_i.bit_position[2:0];
    in_span = {5'd0, in_bit} + {1'b0, req_i.field_length};
    in_next = {1'b0, req_i.bit_position} + {5'd0, req_i.field_length};
    if (in_span <= 8'd8) begin
      in_grp = 4'd1;
    end else if (in_span <= 8'd16) begin
      in_grp = 4'd2;
    end else if (in_span <= 8'd32) begin
      in_grp = 4'd4;
    end else begin
      in_grp = 4'd8;
    end
    in_end = 32'(in_base) + 32'(in_grp);
    if (in_span > 8'd64) begin
      in_status = bfie_pkg::STAT_SPAN;
    end else if (in_end > 32'(bfie_pkg::STORE_BYTES)) begin
      in_status = bfie_pkg::STAT_RANGE;
    end else begin
      in_status = bfie_pkg::STAT_OK;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + RAW'(1);
        if (clr_cnt_q == RAW'(bfie_pkg::ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_MOD;
      ST_MOD:   state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      done_q    <= (state_q == ST_MOD);
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Capture the request and its decode on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_i;
      base_q   <= in_base;
      bit_q    <= in_bit;
      span_q   <= in_span;
      grp_q    <= in_grp;
      next_q   <= in_next;
      status_q <= in_status;
    end
  end

  // Assemble the group: lane i is byte base+i. Native order puts lane 0 at
  // the bottom, byte-reversed order at the top of the 64-bit word.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      for (int i = 0; i < NB; i++) begin
        if (req_q.little_endian) begin
          word_q[8*(NB-1-i) +: 8] <= bank_rdata[3'(base_q[2:0] + 3'(i))];
        end else begin
          word_q[8*i +: 8] <= bank_rdata[3'(base_q[2:0] + 3'(i))];
        end
      end
    end
  end

  // Shift and merge. Byte-reversed: field starts at bit 64-span, so
  // bytes past the group stay untouched at the bottom of the word.
  always_comb begin
    if (req_q.little_endian) begin
      shamt = 7'(8'd64 - span_q);
    end else begin
      shamt = {4'd0, bit_q};
    end
    fmask     = bfie_pkg::len_mask(req_q.field_length);
    extracted = (word_q >> shamt) & fmask;
    merged    = (word_q & ~(fmask << shamt)) | ((req_q.field_value & fmask) << shamt);
    write_ok  = (state_q == ST_MOD) && (status_q == bfie_pkg::STAT_OK) &&
                (req_q.op == bfie_pkg::OP_INSERT);
  end

  // Bank ports: clear sweep, read at transfer, write back in modify.
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [2:0] lane;
    assign lane = 3'(b) - base_q[2:0];

    always_comb begin
      bank_we[b]    = 1'b0;
      bank_wdata[b] = '0;
      bank_addr[b]  = bank_row(base_q, b);
      case (state_q)
        ST_CLEAR: begin
          bank_we[b]   = 1'b1;
          bank_addr[b] = clr_cnt_q;
        end
        ST_IDLE: begin
          bank_addr[b] = bank_row(in_base, b);
        end
        ST_MOD: begin
          bank_we[b] = write_ok && ({1'b0, lane} < grp_q);
          if (req_q.little_endian) begin
            bank_wdata[b] = merged[8*(NB-1) - 8*lane +: 8];
          end else begin
            bank_wdata[b] = merged[8*lane +: 8];
          end
        end
        default: ;
      endcase
    end

    bfie_ram #(
      .WIDTH(8),
      .DEPTH(bfie_pkg::ROWS)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[b]),
      .addr_i (bank_addr[b]),
      .wdata_i(bank_wdata[b]),
      .rdata_o(bank_rdata[b])
    );
  end

  // Result register; drop the value on insert or error.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MOD) begin
      rsp_q.status <= status_q;
      if (status_q == bfie_pkg::STAT_OK && req_q.op == bfie_pkg::OP_EXTRACT) begin
        rsp_q.read_value <= extracted;
      end else begin
        rsp_q.read_value <= '0;
      end
      if (status_q != bfie_pkg::STAT_OK && req_q.little_endian) begin
        rsp_q.next_position <= '0;
      end else begin
        rsp_q.next_position <= next_q;
      end
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Result strobe only follows the modify cycle.
  a_done_after_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_MOD))
    else $error("result strobe without a modify cycle");

  // Bank 0 of the store only changes on a clean insert or during the clearing pass.
  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_we[0] && state_q != ST_CLEAR) |->
      (status_q == bfie_pkg::STAT_OK && req_q.op == bfie_pkg::OP_INSERT))
    else $error("bank write on a failed or extract item");

  // Errors never return data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != bfie_pkg::STAT_OK) |-> (rsp_o.read_value == 64'd0))
    else $error("error result carries a value");

  // No result, and so no transfer, until the clearing pass has finished.
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !done_o)
    else $error("result during clearing pass");

endmodule

// ===== src/bfie_ram.sv =====
// ----------------------------------------------------------------------------
// bfie_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bfie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
